### hdl/sfk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfk_pkg
// Shared types and constants for the skeleton forward kinematics block.
// ----------------------------------------------------------------------------
package sfk_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_POSE = 1'b1;

  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  // controller -> datapath commands
  typedef struct packed {
    logic        ld_item;    // capture item fields
    logic        a_rd;       // issue A memory read (bind or world)
    logic        a_world;    // A comes from world table (else bind)
    logic        rot_en;     // write rotation element idx into B
    logic        copy_b;     // B <= A (local = bind)
    logic        mac_en;     // compute element idx of A*B into C
    logic        c_to_b;     // B <= C
    logic        wr_world;   // write B element idx to world table
    logic        out_load;   // load output row from B
    logic [3:0]  idx;        // element index
    logic [1:0]  row;        // output row
  } sfk_cmd_t;

  // saturate a 64-bit value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] mx;
    logic signed [63:0] mn;
    begin
      mx = 64'sh0000_0000_7FFF_FFFF;
      mn = -64'sh0000_0000_8000_0000;
      if (v > mx) sat32 = 32'sh7FFF_FFFF;
      else if (v < mn) sat32 = 32'sh8000_0000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

### hdl/skeleton_forward_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skeleton_forward_kinematics
// Bind table load and joint pose: world = parent_world * bind * rot(q).
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | command .. quat_z
//  out     | out_valid / out_ready| out_joint, row_index, col0..col3, last_row
//
// Load beats are accepted back to back. A pose runs a bind read, a rotation
// build and a product (pose only), one copy, then a parent read, a product
// and one copy (parent only), a world write and four row beats; the products
// run element by element in the dot-product unit, and in_ready returns the
// cycle after the last row beat. Tables are not cleared at reset; rst only
// clears the sequencer. A stalled output holds the sequencer in the row
// stage.
// ----------------------------------------------------------------------------
module skeleton_forward_kinematics #(
  parameter int MAX_JOINTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [5:0]         joint_index,
  input  logic [3:0]         element_index,
  input  logic signed [31:0] bind_value,
  input  logic               has_pose,
  input  logic               has_parent,
  input  logic [5:0]         parent_index,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_joint,
  output logic [1:0]         row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic               last_row
);

  sfk_pkg::sfk_cmd_t cmd;
  logic jnt_ok;
  logic par_ok;

  sfk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .jnt_ok    (jnt_ok),
    .has_pose  (has_pose),
    .par_ok    (par_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sfk_dp #(.MAX_JOINTS(MAX_JOINTS)) u_dp (
    .clk           (clk),
    .in_beat       (in_valid && in_ready),
    .command       (command),
    .joint_index   (joint_index),
    .element_index (element_index),
    .bind_value    (bind_value),
    .has_parent    (has_parent),
    .parent_index  (parent_index),
    .quat_w        (quat_w),
    .quat_x        (quat_x),
    .quat_y        (quat_y),
    .quat_z        (quat_z),
    .cmd           (cmd),
    .jnt_ok        (jnt_ok),
    .par_ok        (par_ok),
    .out_joint     (out_joint),
    .row_index     (row_index),
    .col0          (col0),
    .col1          (col1),
    .col2          (col2),
    .col3          (col3),
    .last_row      (last_row)
  );

endmodule

### hdl/sfk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfk_ctrl
// Sequencer: reads the bind matrix, builds rotation, runs up to two matrix
// products one element a step, writes world rows and hands out four rows.
// ----------------------------------------------------------------------------
module sfk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic              jnt_ok,
  input  logic              has_pose,
  input  logic              par_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output sfk_pkg::sfk_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDB   = 4'd1;  // read bind into A
  localparam logic [3:0] S_ROT   = 4'd2;  // build rotation in B
  localparam logic [3:0] S_MUL1  = 4'd3;  // C = bind * rot
  localparam logic [3:0] S_CP1   = 4'd4;  // B = local
  localparam logic [3:0] S_RDW   = 4'd5;  // read parent world into A
  localparam logic [3:0] S_MUL2  = 4'd6;  // C = world * local
  localparam logic [3:0] S_CP2   = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;  // store world
  localparam logic [3:0] S_OUT   = 4'd9;  // emit rows

  logic [3:0] state;
  logic [3:0] state_next;
  logic [4:0] cnt;
  logic [4:0] cnt_next;
  logic       pose;
  logic       pose_next;
  logic       par;
  logic       par_next;
  logic       ovalid;
  logic       ovalid_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = ovalid;

  // Next-state and command decode
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    pose_next   = pose;
    par_next    = par;
    ovalid_next = ovalid;
    cmd         = '0;
    cmd.idx     = cnt[3:0];
    cmd.row     = cnt[1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          if (command == sfk_pkg::CMD_POSE && jnt_ok) begin
            pose_next  = has_pose;
            par_next   = par_ok;
            cnt_next   = '0;
            state_next = S_RDB;
          end
        end
      end
      S_RDB: begin
        // read data is registered; cnt counts 0..16
        cmd.a_rd = (cnt < 5'd16);
        if (cnt == 5'd16) begin
          cnt_next   = '0;
          state_next = pose ? S_ROT : S_CP1;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_ROT: begin
        cmd.rot_en = 1'b1;
        cnt_next   = cnt + 5'd1;
        if (cnt == 5'd15) begin
          cnt_next   = '0;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mac_en = 1'b1;
        cnt_next   = cnt + 5'd1;
        if (cnt == 5'd15) begin
          cnt_next   = '0;
          state_next = S_CP1;
        end
      end
      S_CP1: begin
        if (pose) cmd.c_to_b = 1'b1;
        else      cmd.copy_b = 1'b1;
        cnt_next   = '0;
        state_next = par ? S_RDW : S_WR;
      end
      S_RDW: begin
        cmd.a_rd    = (cnt < 5'd16);
        cmd.a_world = 1'b1;
        if (cnt == 5'd16) begin
          cnt_next   = '0;
          state_next = S_MUL2;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_MUL2: begin
        cmd.mac_en = 1'b1;
        cnt_next   = cnt + 5'd1;
        if (cnt == 5'd15) begin
          cnt_next   = '0;
          state_next = S_CP2;
        end
      end
      S_CP2: begin
        cmd.c_to_b = 1'b1;
        cnt_next   = '0;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_world = 1'b1;
        cnt_next     = cnt + 5'd1;
        if (cnt == 5'd15) begin
          cnt_next    = '0;
          cmd.out_load = 1'b1;
          cmd.row      = 2'd0;
          ovalid_next  = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (cnt[1:0] == 2'd3) begin
            ovalid_next = 1'b0;
            cnt_next    = '0;
            state_next  = S_IDLE;
          end else begin
            cmd.out_load = 1'b1;
            cmd.row      = cnt[1:0] + 2'd1;
            cnt_next     = cnt + 5'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      pose   <= 1'b0;
      par    <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      pose   <= pose_next;
      par    <= par_next;
      ovalid <= ovalid_next;
    end
  end

endmodule

### hdl/sfk_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfk_dp
// Datapath: bind and world tables, A/B/C matrix stores, rotation element
// unit and a four-multiplier dot-product unit (one element per cycle).
// ----------------------------------------------------------------------------
module sfk_dp #(
  parameter int MAX_JOINTS = 64
) (
  input  logic                     clk,
  input  logic                     in_beat,
  input  logic                     command,
  input  logic [5:0]               joint_index,
  input  logic [3:0]               element_index,
  input  logic signed [31:0]       bind_value,
  input  logic                     has_parent,
  input  logic [5:0]               parent_index,
  input  logic signed [15:0]       quat_w,
  input  logic signed [15:0]       quat_x,
  input  logic signed [15:0]       quat_y,
  input  logic signed [15:0]       quat_z,
  input  sfk_pkg::sfk_cmd_t        cmd,
  output logic                     jnt_ok,
  output logic                     par_ok,
  output logic [5:0]               out_joint,
  output logic [1:0]               row_index,
  output logic signed [31:0]       col0,
  output logic signed [31:0]       col1,
  output logic signed [31:0]       col2,
  output logic signed [31:0]       col3,
  output logic                     last_row
);

  localparam int DEPTH = MAX_JOINTS * 16;
  localparam int AW    = $clog2(DEPTH);

  logic signed [31:0] bind_mem  [DEPTH];
  logic signed [31:0] world_mem [DEPTH];

  logic [5:0]          jnt;
  logic [5:0]          par;
  logic signed [15:0]  qw, qx, qy, qz;
  logic signed [31:0]  a_m [16];
  logic signed [31:0]  b_m [16];
  logic signed [31:0]  c_m [16];
  logic signed [31:0]  rd_data;
  logic                rd_vld;
  logic [3:0]          rd_idx;

  assign jnt_ok = ({3'b000, joint_index} < 9'(MAX_JOINTS));
  assign par_ok = has_parent && ({3'b000, parent_index} < 9'(MAX_JOINTS));

  // Bind table write on load beats
  always_ff @(posedge clk) begin
    if (in_beat && command == sfk_pkg::CMD_LOAD && jnt_ok)
      bind_mem[AW'({joint_index, element_index})] <= bind_value;
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      jnt <= joint_index;
      par <= parent_index;
      qw  <= quat_w;
      qx  <= quat_x;
      qy  <= quat_y;
      qz  <= quat_z;
    end
  end

  // Table reads, one element a cycle, data registered
  always_ff @(posedge clk) begin
    rd_vld <= cmd.a_rd;
    rd_idx <= cmd.idx;
    if (cmd.a_world) rd_data <= world_mem[AW'({par, cmd.idx})];
    else             rd_data <= bind_mem[AW'({jnt, cmd.idx})];
    if (rd_vld) a_m[rd_idx] <= rd_data;
  end

  // World write from B
  always_ff @(posedge clk) begin
    if (cmd.wr_world) world_mem[AW'({jnt, cmd.idx})] <= b_m[cmd.idx];
  end

  // Rotation element: two products and a sum or difference in Q.28
  logic signed [15:0] ra1, rb1, ra2, rb2;
  logic               rsub, rdiag, rzero, rone;
  logic signed [31:0] rp1, rp2;
  logic signed [35:0] racc;
  logic signed [35:0] rq16;
  logic signed [31:0] rot_val;

  always_comb begin
    ra1 = qy; rb1 = qy; ra2 = qz; rb2 = qz;
    rsub = 1'b0; rdiag = 1'b0; rzero = 1'b0; rone = 1'b0;
    case (cmd.idx)
      4'd0:  begin ra1 = qy; rb1 = qy; ra2 = qz; rb2 = qz; rdiag = 1'b1; end
      4'd1:  begin ra1 = qx; rb1 = qy; ra2 = qw; rb2 = qz; rsub = 1'b1; end
      4'd2:  begin ra1 = qx; rb1 = qz; ra2 = qw; rb2 = qy; end
      4'd4:  begin ra1 = qx; rb1 = qy; ra2 = qw; rb2 = qz; end
      4'd5:  begin ra1 = qx; rb1 = qx; ra2 = qz; rb2 = qz; rdiag = 1'b1; end
      4'd6:  begin ra1 = qy; rb1 = qz; ra2 = qw; rb2 = qx; rsub = 1'b1; end
      4'd8:  begin ra1 = qx; rb1 = qz; ra2 = qw; rb2 = qy; rsub = 1'b1; end
      4'd9:  begin ra1 = qy; rb1 = qz; ra2 = qw; rb2 = qx; end
      4'd10: begin ra1 = qx; rb1 = qx; ra2 = qy; rb2 = qy; rdiag = 1'b1; end
      4'd15: rone = 1'b1;
      default: rzero = 1'b1;
    endcase
    rp1 = ra1 * rb1;
    rp2 = ra2 * rb2;
    if (rdiag)
      racc = (36'sd1 <<< 28) - (36'(rp1) + 36'(rp2)) * 36'sd2;
    else if (rsub)
      racc = (36'(rp1) - 36'(rp2)) * 36'sd2;
    else
      racc = (36'(rp1) + 36'(rp2)) * 36'sd2;
    rq16 = (racc + 36'sd2048) >>> 12;
    if (rone)       rot_val = sfk_pkg::ONE_Q16;
    else if (rzero) rot_val = '0;
    else            rot_val = sfk_pkg::sat32(64'(rq16));
  end

  // Dot product of row r of A with column c of B
  logic [1:0]         mr, mc;
  logic signed [63:0] prod [4];
  logic signed [63:0] hi_sum;
  logic [18:0]        lo_sum;
  logic signed [31:0] mac_val;

  always_comb begin
    mr = cmd.idx[3:2];
    mc = cmd.idx[1:0];
    hi_sum = '0;
    lo_sum = '0;
    for (int k = 0; k < 4; k++) begin
      prod[k] = a_m[{mr, 2'(k)}] * b_m[{2'(k), mc}];
      hi_sum  = hi_sum + (prod[k] >>> 16);
      lo_sum  = lo_sum + {3'b000, prod[k][15:0]};
    end
    mac_val = sfk_pkg::sat32(hi_sum + 64'((lo_sum + 19'd32768) >> 16));
  end

  // Matrix stores
  always_ff @(posedge clk) begin
    if (cmd.rot_en) b_m[cmd.idx] <= rot_val;
    if (cmd.mac_en) c_m[cmd.idx] <= mac_val;
    for (int i = 0; i < 16; i++) begin
      if (cmd.copy_b) b_m[i] <= a_m[i];
      if (cmd.c_to_b) b_m[i] <= c_m[i];
    end
  end

  // Output row register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_joint <= jnt;
      row_index <= cmd.row;
      col0      <= b_m[{cmd.row, 2'd0}];
      col1      <= b_m[{cmd.row, 2'd1}];
      col2      <= b_m[{cmd.row, 2'd2}];
      col3      <= b_m[{cmd.row, 2'd3}];
      last_row  <= (cmd.row == 2'd3);
    end
  end

endmodule

### hdl/sfk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfk_checker
// Port-level checks on row ordering and busy behavior.
// ----------------------------------------------------------------------------
module sfk_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] row_index,
  input logic       last_row
);

  // last_row marks row three only
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (row_index == 2'd3)))
    else $error("last_row mismatch");

  // rows advance by one after a non-final beat
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_row) |=> (out_valid && row_index == $past(row_index) + 2'd1))
    else $error("row order broken");

  // no input taken while rows are pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(in_valid && in_ready))
    else $error("input accepted during output");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(row_index)))
    else $error("output dropped");

endmodule

bind skeleton_forward_kinematics sfk_checker u_sfk_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .row_index (row_index),
  .last_row  (last_row)
);

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Bind matrix loads and joint poses with random bursts on the input side and
// output stalls, checked row by row against a local forward kinematics
// predictor that keeps its own copy of the bind and world tables.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [15:0][31:0] mat_t;

  typedef struct {
    bit                 drain;
    logic               cmd;
    logic [5:0]         jnt;
    logic [3:0]         elem;
    logic signed [31:0] bval;
    logic               hp;
    logic               hpar;
    logic [5:0]         par;
    logic signed [15:0] qw, qx, qy, qz;
  } beat_t;

  typedef struct {
    logic [5:0]  jnt;
    logic [1:0]  row;
    logic [31:0] c0, c1, c2, c3;
    logic        last;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic [5:0] joint_index = '0;
  logic [3:0] element_index = '0;
  logic signed [31:0] bind_value = '0;
  logic has_pose = 1'b0;
  logic has_parent = 1'b0;
  logic [5:0] parent_index = '0;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_joint;
  logic [1:0] row_index;
  logic signed [31:0] col0, col1, col2, col3;
  logic last_row;

  skeleton_forward_kinematics u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .joint_index(joint_index), .element_index(element_index),
    .bind_value(bind_value), .has_pose(has_pose), .has_parent(has_parent),
    .parent_index(parent_index),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_joint(out_joint), .row_index(row_index),
    .col0(col0), .col1(col1), .col2(col2), .col3(col3), .last_row(last_row)
  );

  always #5 clk = ~clk;

  beat_t pending[$];
  row_t  rows_due[$];
  int    errors = 0;

  // predictor tables
  mat_t bind_tab[64];
  mat_t world_tab[64];

  // stimulus bookkeeping: which entries have been written
  logic [15:0] bind_mask[64];
  bit          world_ok[64];
  int          n_items = 0;

  function automatic logic [31:0] clip(input logic signed [67:0] v);
    if (v > 68'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -68'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // C = A * B in Q16.16, exact sum of four products, round half up
  function automatic mat_t mat_product(input mat_t a, input mat_t b);
    mat_t m;
    logic signed [67:0] acc, ea, eb;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) begin
          ea = 68'($signed(a[r*4+k]));
          eb = 68'($signed(b[k*4+c]));
          acc = acc + ea * eb;
        end
        m[r*4+c] = clip((acc + 68'sd32768) >>> 16);
      end
    end
    return m;
  endfunction

  function automatic logic [31:0] q28_round(input longint v);
    logic signed [67:0] e;
    e = 68'(v) + 68'sd2048;
    return clip(e >>> 12);
  endfunction

  // rotation matrix of an unnormalized Q1.14 quaternion
  function automatic mat_t rot_matrix(input longint w, x, y, z);
    mat_t m;
    longint one;
    one = 64'sd1 << 28;
    m = '0;
    m[0]  = q28_round(one - 2 * (y*y + z*z));
    m[1]  = q28_round(2 * (x*y - w*z));
    m[2]  = q28_round(2 * (x*z + w*y));
    m[4]  = q28_round(2 * (x*y + w*z));
    m[5]  = q28_round(one - 2 * (x*x + z*z));
    m[6]  = q28_round(2 * (y*z - w*x));
    m[8]  = q28_round(2 * (x*z - w*y));
    m[9]  = q28_round(2 * (y*z + w*x));
    m[10] = q28_round(one - 2 * (x*x + y*y));
    m[15] = sfk_pkg::ONE_Q16;
    return m;
  endfunction

  // update tables for one accepted beat and queue the rows it produces
  task automatic apply_beat(input beat_t b);
    mat_t loc, wm;
    row_t rw;
    if (b.cmd == sfk_pkg::CMD_LOAD) begin
      bind_tab[b.jnt][b.elem] = b.bval;
    end else begin
      loc = b.hp ? mat_product(bind_tab[b.jnt], rot_matrix(b.qw, b.qx, b.qy, b.qz))
                 : bind_tab[b.jnt];
      wm = b.hpar ? mat_product(world_tab[b.par], loc) : loc;
      world_tab[b.jnt] = wm;
      for (int r = 0; r < 4; r++) begin
        rw.jnt = b.jnt; rw.row = r[1:0];
        rw.c0 = wm[r*4]; rw.c1 = wm[r*4+1]; rw.c2 = wm[r*4+2]; rw.c3 = wm[r*4+3];
        rw.last = (r == 3);
        rows_due.insert(rows_due.size(), rw);
      end
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------- stimulus building ----------------
  function automatic logic signed [31:0] pick_bind();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: case ($urandom_range(0, 3))
           0: return 32'sh7FFF_FFFF;
           1: return 32'sh8000_0000;
           2: return -32'sd1;
           default: return 32'sd0;
         endcase
      default: return $signed($urandom_range(0, 524288)) - 32'sd262144;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_quat();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
    endcase
  endfunction

  task automatic add_load(input logic [5:0] j, input logic [3:0] e, input logic signed [31:0] v);
    beat_t b;
    b = '{default: '0};
    b.cmd = sfk_pkg::CMD_LOAD; b.jnt = j; b.elem = e; b.bval = v;
    // fields that a load ignores still toggle
    b.hp = 1'($urandom); b.hpar = 1'($urandom); b.par = 6'($urandom);
    b.qw = 16'($urandom); b.qx = 16'($urandom); b.qy = 16'($urandom); b.qz = 16'($urandom);
    bind_mask[j][e] = 1'b1;
    pending.insert(pending.size(), b);
    n_items++;
  endtask

  // pose of a joint whose bind matrix is complete; parent only if written
  task automatic add_pose(input logic [5:0] j);
    beat_t b;
    int cand[$];
    b = '{default: '0};
    b.cmd = sfk_pkg::CMD_POSE; b.jnt = j; b.elem = 4'($urandom); b.bval = $urandom;
    b.hp = ($urandom_range(0, 4) != 0);
    b.qw = pick_quat(); b.qx = pick_quat(); b.qy = pick_quat(); b.qz = pick_quat();
    for (int i = 0; i < 64; i++) if (world_ok[i]) cand.insert(cand.size(), i);
    b.par = 6'($urandom);
    b.hpar = 1'b0;
    if (cand.size() > 0 && $urandom_range(0, 3) != 0) begin
      b.hpar = 1'b1;
      b.par = 6'(cand[$urandom_range(0, cand.size() - 1)]);
    end
    world_ok[j] = 1'b1;
    pending.insert(pending.size(), b);
    n_items++;
  endtask

  task automatic add_drain();
    beat_t b;
    b = '{default: '0};
    b.drain = 1'b1;
    pending.insert(pending.size(), b);
  endtask

  task automatic build_stimulus();
    int order[16];
    int ready[$];
    int j, sw, t;
    // directed: joint 0 with extreme bind values
    for (int e = 0; e < 16; e++) begin
      case (e % 4)
        0: add_load(6'd0, 4'(e), 32'sh7FFF_FFFF);
        1: add_load(6'd0, 4'(e), 32'sh8000_0000);
        2: add_load(6'd0, 4'(e), -32'sd1);
        default: add_load(6'd0, 4'(e), (e == 15) ? sfk_pkg::ONE_Q16 : 32'sd0);
      endcase
    end
    // root without pose
    add_pose(6'd0);
    pending[$].hp = 1'b0; pending[$].hpar = 1'b0;
    // root, identity quaternion
    add_pose(6'd0);
    pending[$].hp = 1'b1; pending[$].hpar = 1'b0;
    pending[$].qw = 16'sd16384; pending[$].qx = '0; pending[$].qy = '0; pending[$].qz = '0;
    // own parent, quaternion extremes
    add_pose(6'd0);
    pending[$].hp = 1'b1; pending[$].hpar = 1'b1; pending[$].par = 6'd0;
    pending[$].qw = 16'sh8000; pending[$].qx = 16'sh7FFF;
    pending[$].qy = 16'sh8000; pending[$].qz = 16'sh7FFF;
    // own parent, no pose
    add_pose(6'd0);
    pending[$].hp = 1'b0; pending[$].hpar = 1'b1; pending[$].par = 6'd0;
    add_drain();

    // random: mostly full bind loads followed by poses
    while (n_items < 500) begin
      if (n_items > 250 && n_items < 270) add_drain();
      t = $urandom_range(0, 9);
      if (t < 6) begin
        j = $urandom_range(0, 63);
        for (int i = 0; i < 16; i++) order[i] = i;
        for (int i = 15; i > 0; i--) begin
          sw = $urandom_range(0, i);
          {order[i], order[sw]} = {order[sw], order[i]};
        end
        for (int i = 0; i < 16; i++) add_load(6'(j), 4'(order[i]), pick_bind());
        repeat ($urandom_range(1, 3)) add_pose(6'(j));
      end else if (t < 8) begin
        add_load(6'($urandom), 4'($urandom), pick_bind());
      end else begin
        ready.delete();
        for (int i = 0; i < 64; i++)
          if (bind_mask[i] == 16'hFFFF) ready.insert(ready.size(), i);
        if (ready.size() > 0) add_pose(6'(ready[$urandom_range(0, ready.size() - 1)]));
      end
    end
  endtask

  // ---------------- driver ----------------
  beat_t cur;
  bit    in_took = 1'b0;
  logic  nv;
  int    gap_left = 0;
  int    burst_left = 0;
  int    settle_cnt = 0;

  always @(posedge clk) begin
    in_took = !rst && in_valid && in_ready;
    if (in_took) apply_beat(cur);
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      nv = 1'b0;
      if (pending.size() > 0 && pending[0].drain) begin
        // hold off until every queued row has come out
        if (rows_due.size() == 0) begin
          if (settle_cnt == 40) begin
            void'(pending.pop_front());
            settle_cnt = 0;
          end else begin
            settle_cnt++;
          end
        end
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() > 0) begin
        cur = pending.pop_front();
        command <= cur.cmd; joint_index <= cur.jnt; element_index <= cur.elem;
        bind_value <= cur.bval; has_pose <= cur.hp; has_parent <= cur.hpar;
        parent_index <= cur.par;
        quat_w <= cur.qw; quat_x <= cur.qx; quat_y <= cur.qy; quat_z <= cur.qz;
        nv = 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
      in_valid <= nv;
    end
  end

  // ---------------- receiver stall pattern ----------------
  logic [7:0] ready_cnt = '0;

  always @(negedge clk) begin
    ready_cnt <= ready_cnt + 1'b1;
    case (ready_cnt[7:6])
      2'b01: out_ready <= ($urandom_range(0, 3) == 0);
      2'b11: out_ready <= 1'($urandom);
      default: out_ready <= 1'b1;
    endcase
  end

  // ---------------- monitor ----------------
  row_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (rows_due.size() == 0) begin
        report("unexpected row beat, joint", 32'(out_joint), 32'd0);
      end else begin
        want = rows_due.pop_front();
        if (out_joint !== want.jnt) report("out_joint", 32'(out_joint), 32'(want.jnt));
        if (row_index !== want.row) report("row_index", 32'(row_index), 32'(want.row));
        if (col0 !== want.c0) report("col0", col0, want.c0);
        if (col1 !== want.c1) report("col1", col1, want.c1);
        if (col2 !== want.c2) report("col2", col2, want.c2);
        if (col3 !== want.c3) report("col3", col3, want.c3);
        if (last_row !== want.last) report("last_row", 32'(last_row), 32'(want.last));
      end
    end
  end

  // ---------------- sequence and end of run ----------------
  initial begin
    for (int i = 0; i < 64; i++) begin
      bind_mask[i] = '0;
      world_ok[i] = 1'b0;
      bind_tab[i] = '0;
      world_tab[i] = '0;
    end
    build_stimulus();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    do @(posedge clk);
    while (pending.size() != 0 || in_valid || rows_due.size() != 0);
    repeat (200) @(posedge clk);
    if (rows_due.size() != 0) begin
      $display("%0d rows never came out", rows_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
